// ----- src/bsmh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmh_pkg: shared types and constants for the byte stream mix hash
// Holds the lane start values, the mixing multipliers and the sequencer states.
// ----------------------------------------------------------------------------
package bsmh_pkg;

  // Lane start values, restored after reset and after every message.
  localparam logic [31:0] LANE_ONE_START = 32'hdeadbeef;
  localparam logic [31:0] LANE_TWO_START = 32'h41c6ce57;

  // Per-byte absorb multipliers.
  localparam logic [31:0] MUL_ONE = 32'h85ebca77;
  localparam logic [31:0] MUL_TWO = 32'hc2b2ae3d;

  // Finalization multipliers.
  localparam logic [31:0] FIN_MUL_ONE = 32'h735a2d97;
  localparam logic [31:0] FIN_MUL_TWO = 32'hcaf649a9;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS2,
    ST_WB2,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } seq_state_t;

endpackage

// ----- src/bsmh_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsmh_mul: shared 32x32 wrapping multiplier
// Forms the low 32 bits of the product and registers it when enabled.
// ----------------------------------------------------------------------------
module bsmh_mul (
  input  logic        clk,
  input  logic        mul_en,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [31:0] prod_r
);

  logic [31:0] prod_low;

  // Only the low word of the product is formed, which is the modulo 2^32 result.
  assign prod_low = op_a * op_b;

  // Product register; it holds its value while the sequencer waits.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_low;
    end
  end

endmodule

// ----- src/byte_stream_mix_hash32.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_mix_hash32: streaming 32-bit two-lane multiplicative hash
// Absorbs one message byte per request into two 32-bit lanes and, at the end
// of a message, cross-mixes the lanes and returns a 32-bit hash.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_ready   in_data_byte, in_byte_present,
//                                            in_last_byte
//   out_      output     out_valid/out_ready out_hash_value
//
// A request carrying a byte uses ST_IDLE and ST_ABS2: both lane multiplies go
// through the one shared 32x32 multiplier, one per cycle. A request with no
// byte and no end mark is taken in ST_IDLE alone. An end-of-message request
// with a byte runs the two absorb multiplies, the lane-two write-back, the
// two finalization multiplies and the output step; one without, the last three.
// The hash sits in an output register, so a new message may start while it
// waits; a second hash stalls in the last finalization step until it is taken.
// Reset (rst_n low, synchronous) loads the lane start values and empties the
// output register.
// ----------------------------------------------------------------------------
module byte_stream_mix_hash32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);

  import bsmh_pkg::*;

  seq_state_t  state_r, state_nxt;
  logic [31:0] lane_one_r, lane_one_nxt;
  logic [31:0] lane_two_r, lane_two_nxt;
  logic        wb_pend_r, wb_pend_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic        in_acc;
  logic        out_free;
  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] mul_q;
  logic [31:0] a_fin;
  logic [31:0] b_fin;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Intermediate finalization values built from the registered product.
  assign a_fin = lane_one_r ^ mul_q;
  assign b_fin = lane_two_r ^ mul_q;

  // Shared multiplier.
  bsmh_mul u_mul (
    .clk    (clk),
    .mul_en (mul_en),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_q)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_byte_present) begin
            state_nxt = ST_ABS2;
          end else if (in_last_byte) begin
            state_nxt = ST_FIN1;
          end
        end
      end
      ST_ABS2: state_nxt = last_r ? ST_WB2 : ST_IDLE;
      ST_WB2:  state_nxt = ST_FIN1;
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: state_nxt = ST_FIN3;
      ST_FIN3: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier operand selection; the lane-one multiply starts on acceptance.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = 32'd0;
    mul_b  = 32'd0;
    case (state_r)
      ST_IDLE: begin
        mul_en = 1'b1;
        mul_a  = lane_one_r ^ {24'd0, in_data_byte};
        mul_b  = MUL_ONE;
      end
      ST_ABS2: begin
        mul_en = 1'b1;
        mul_a  = lane_two_r ^ {24'd0, byte_r};
        mul_b  = MUL_TWO;
      end
      ST_FIN1: begin
        mul_en = 1'b1;
        mul_a  = lane_one_r ^ (lane_two_r >> 15);
        mul_b  = FIN_MUL_ONE;
      end
      ST_FIN2: begin
        mul_en = 1'b1;
        mul_a  = lane_two_r ^ (a_fin >> 15);
        mul_b  = FIN_MUL_TWO;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    lane_one_nxt  = lane_one_r;
    lane_two_nxt  = lane_two_r;
    wb_pend_nxt   = wb_pend_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_IDLE: begin
        // Finish the lane-two update left over from the previous byte.
        if (wb_pend_r) begin
          lane_two_nxt = mul_q;
          wb_pend_nxt  = 1'b0;
        end
        if (in_acc) begin
          byte_nxt = in_data_byte;
          last_nxt = in_last_byte;
        end
      end
      ST_ABS2: begin
        lane_one_nxt = mul_q;
        wb_pend_nxt  = !last_r;
      end
      ST_WB2: begin
        lane_two_nxt = mul_q;
      end
      ST_FIN2: begin
        lane_one_nxt = a_fin;
      end
      ST_FIN3: begin
        if (out_free) begin
          out_hash_nxt  = lane_one_r ^ (b_fin >> 16);
          out_valid_nxt = 1'b1;
          lane_one_nxt  = LANE_ONE_START;
          lane_two_nxt  = LANE_TWO_START;
        end
      end
      default: begin
        wb_pend_nxt = wb_pend_r;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  // Control and lane state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_one_r  <= LANE_ONE_START;
      lane_two_r  <= LANE_TWO_START;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_one_r  <= lane_one_nxt;
      lane_two_r  <= lane_two_nxt;
      wb_pend_r   <= wb_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

endmodule
